// File: hdl/ect_pkg.sv
`timescale 1ns / 1ps

package ect_pkg;

  typedef logic [3:0] token_kind_t;

  localparam token_kind_t KIND_NUMBER = 4'd0;
  localparam token_kind_t KIND_WORD   = 4'd1;
  localparam token_kind_t KIND_PLUS   = 4'd2;
  localparam token_kind_t KIND_MINUS  = 4'd3;
  localparam token_kind_t KIND_MUL    = 4'd4;
  localparam token_kind_t KIND_DIV    = 4'd5;
  localparam token_kind_t KIND_POINT  = 4'd6;
  localparam token_kind_t KIND_LPAREN = 4'd7;
  localparam token_kind_t KIND_RPAREN = 4'd8;
  localparam token_kind_t KIND_END    = 4'd9;

  localparam int unsigned DEC_BASE = 10;

  typedef enum logic [1:0] {
    CC_OP,
    CC_DIGIT,
    CC_WORD
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    token_kind_t kind;
  } char_info_t;

  // Sort one character into operator, digit or word character.
  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t info;
    info.cls  = CC_OP;
    info.kind = KIND_WORD;
    case (c)
      8'h2b: info.kind = KIND_PLUS;
      8'h2d: info.kind = KIND_MINUS;
      8'h2a: info.kind = KIND_MUL;
      8'h2f: info.kind = KIND_DIV;
      8'h2e: info.kind = KIND_POINT;
      8'h28: info.kind = KIND_LPAREN;
      8'h29: info.kind = KIND_RPAREN;
      default: begin
        if (c inside {[8'h30:8'h39]}) begin
          info.cls = CC_DIGIT;
        end else begin
          info.cls = CC_WORD;
        end
      end
    endcase
    return info;
  endfunction

endpackage

// File: hdl/ect_in_if.sv
`timescale 1ns / 1ps

interface ect_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

// File: hdl/ect_out_if.sv
`timescale 1ns / 1ps

interface ect_out_if;
  import ect_pkg::*;

  logic               valid;
  logic               ready;
  token_kind_t        token_kind;
  logic signed [31:0] number_value;
  logic [7:0]         word_char;
  logic               word_truncated;
  logic               paren_mismatch;
  logic               token_done;
  logic               last;

  modport source (
    output valid, output token_kind, output number_value, output word_char,
    output word_truncated, output paren_mismatch, output token_done, output last,
    input ready
  );
  modport sink (
    input valid, input token_kind, input number_value, input word_char,
    input word_truncated, input paren_mismatch, input token_done, input last,
    output ready
  );
endinterface

// File: hdl/expression_char_tokenizer.sv
`timescale 1ns / 1ps
// Sequence: a digit passes through the multiply-accumulate state; a word character is buffered at idle.
// An operator or end-of-text item passes through the number state, which emits any pending number,
// then a buffer read and an output state for each buffered word character, then the token state.
// An output stall holds the sequencer in its current output state.
// Throughput: one item at a time; the input is not ready until the sequencer is back at idle.
// Reset: asynchronous, active low; clears sequencer, counters and output valid.
module expression_char_tokenizer #(
  parameter int unsigned WORD_CHARS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ect_in_if.sink    in_i,
  ect_out_if.source out_o
);
  import ect_pkg::*;

  localparam int unsigned LEN_W  = $clog2(WORD_CHARS + 1);
  localparam int unsigned ADDR_W = $clog2(WORD_CHARS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_NUM,
    S_WORD,
    S_WOUT,
    S_TOK
  } state_e;

  state_e            state_q;
  token_kind_t       pend_kind_q;
  logic              pend_end_q;
  logic [3:0]        digit_q;
  logic              num_active_q;
  logic              word_active_q;
  logic [LEN_W-1:0]  word_len_q;
  logic              word_ovf_q;
  logic [LEN_W-1:0]  rd_idx_q;
  logic [COUNT_BITS-1:0] open_q;
  logic [COUNT_BITS-1:0] close_q;

  // Output register
  logic               out_valid_q;
  token_kind_t        out_kind_q;
  logic [31:0]        out_num_q;
  logic [7:0]         out_char_q;
  logic               out_trunc_q;
  logic               out_mism_q;
  logic               out_done_q;
  logic               out_last_q;

  logic        accept;
  logic        slot_free;
  logic        emit;
  char_info_t  info;
  logic        buf_we;
  logic        buf_re;
  logic [7:0]  buf_rdata;
  logic        mac_clear;
  logic        mac_step;
  logic [31:0] acc;
  logic        word_fits;
  logic        last_char;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign info       = classify(in_i.text_char);
  assign slot_free  = !out_valid_q || out_o.ready;
  assign word_fits  = (word_len_q < LEN_W'(WORD_CHARS));
  assign last_char  = ((rd_idx_q + LEN_W'(1)) == word_len_q);

  // A new output item loads this cycle.
  assign emit = slot_free && (((state_q == S_NUM) && num_active_q) ||
                              (state_q == S_WOUT) || (state_q == S_TOK));

  // Store a word character while the buffer has room.
  assign buf_we = accept && !in_i.end_of_text && (info.cls == CC_WORD) && word_fits;
  // Fetch the next buffered character during a word flush.
  assign buf_re = (state_q == S_WORD) && word_active_q;

  assign mac_step  = (state_q == S_MAC);
  assign mac_clear = (state_q == S_NUM) && num_active_q && slot_free;

  ect_wbuf #(
    .DEPTH (WORD_CHARS)
  ) u_wbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (word_len_q[ADDR_W-1:0]),
    .wdata_i (in_i.text_char),
    .re_i    (buf_re),
    .raddr_i (rd_idx_q[ADDR_W-1:0]),
    .rdata_o (buf_rdata)
  );

  ect_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mac_clear),
    .step_i  (mac_step),
    .digit_i (digit_q),
    .acc_o   (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pend_kind_q   <= KIND_END;
      pend_end_q    <= 1'b0;
      digit_q       <= '0;
      num_active_q  <= 1'b0;
      word_active_q <= 1'b0;
      word_len_q    <= '0;
      word_ovf_q    <= 1'b0;
      rd_idx_q      <= '0;
      open_q        <= '0;
      close_q       <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_END;
      out_num_q     <= '0;
      out_char_q    <= '0;
      out_trunc_q   <= 1'b0;
      out_mism_q    <= 1'b0;
      out_done_q    <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      // Drop the output item once taken, unless an emit below reloads it.
      if (out_valid_q && out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.end_of_text) begin
              pend_kind_q <= KIND_END;
              pend_end_q  <= 1'b1;
              state_q     <= S_NUM;
            end else begin
              case (info.cls)
                CC_DIGIT: begin
                  digit_q      <= in_i.text_char[3:0];
                  num_active_q <= 1'b1;
                  state_q      <= S_MAC;
                end
                CC_WORD: begin
                  word_active_q <= 1'b1;
                  if (word_fits) begin
                    word_len_q <= word_len_q + LEN_W'(1);
                  end else begin
                    word_ovf_q <= 1'b1;
                  end
                end
                default: begin
                  pend_kind_q <= info.kind;
                  pend_end_q  <= 1'b0;
                  state_q     <= S_NUM;
                end
              endcase
            end
          end
        end

        S_MAC: begin
          state_q <= S_IDLE;
        end

        S_NUM: begin
          if (!num_active_q) begin
            state_q <= S_WORD;
          end else if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= KIND_NUMBER;
            out_num_q    <= acc;
            out_char_q   <= '0;
            out_trunc_q  <= 1'b0;
            out_mism_q   <= 1'b0;
            out_done_q   <= 1'b1;
            out_last_q   <= 1'b0;
            num_active_q <= 1'b0;
            state_q      <= S_WORD;
          end
        end

        S_WORD: begin
          // Read issued here; data shows up for the output cycle.
          state_q <= word_active_q ? S_WOUT : S_TOK;
        end

        S_WOUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_WORD;
            out_num_q   <= '0;
            out_char_q  <= buf_rdata;
            out_trunc_q <= word_ovf_q;
            out_mism_q  <= 1'b0;
            out_done_q  <= last_char;
            out_last_q  <= 1'b0;
            if (last_char) begin
              word_active_q <= 1'b0;
              word_len_q    <= '0;
              word_ovf_q    <= 1'b0;
              rd_idx_q      <= '0;
              state_q       <= S_TOK;
            end else begin
              rd_idx_q <= rd_idx_q + LEN_W'(1);
              state_q  <= S_WORD;
            end
          end
        end

        S_TOK: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= pend_kind_q;
            out_num_q   <= '0;
            out_char_q  <= '0;
            out_trunc_q <= 1'b0;
            out_mism_q  <= pend_end_q && (open_q != close_q);
            out_done_q  <= 1'b1;
            out_last_q  <= 1'b1;
            // Advance paren counters, or clear them at end of text.
            if (pend_end_q) begin
              open_q  <= '0;
              close_q <= '0;
            end else if (pend_kind_q == KIND_LPAREN) begin
              open_q <= open_q + COUNT_BITS'(1);
            end else if (pend_kind_q == KIND_RPAREN) begin
              close_q <= close_q + COUNT_BITS'(1);
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.token_kind     = out_kind_q;
  assign out_o.number_value   = out_num_q;
  assign out_o.word_char      = out_char_q;
  assign out_o.word_truncated = out_trunc_q;
  assign out_o.paren_mismatch = out_mism_q;
  assign out_o.token_done     = out_done_q;
  assign out_o.last           = out_last_q;

endmodule

// File: hdl/ect_wbuf.sv
`timescale 1ns / 1ps

module ect_wbuf #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ect_mac.sv
`timescale 1ns / 1ps

module ect_mac (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        step_i,
  input  logic [3:0]  digit_i,
  output logic [31:0] acc_o
);
  import ect_pkg::*;

  logic [31:0] acc_q;
  logic [31:0] prod;

  // Multiply-accumulate by the decimal base, wrapping at 32 bits.
  assign prod = acc_q * 32'(DEC_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (step_i) begin
      acc_q <= prod + 32'(digit_i);
    end
  end

  assign acc_o = acc_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ect_pkg::*;

  localparam int unsigned WORD_CHARS   = 32;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PAREN_RUN    = 40;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_MUL    = "*";
  localparam logic [7:0] CH_DIV    = "/";
  localparam logic [7:0] CH_POINT  = ".";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";

  localparam logic [7:0] OP_CHARS [7] = '{
    CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POINT, CH_LPAREN, CH_RPAREN
  };

  // One output item as the block should present it.
  typedef struct packed {
    token_kind_t        kind;
    logic signed [31:0] value;
    logic [7:0]         ch;
    logic               trunc;
    logic               mism;
    logic               done;
    logic               last;
  } token_t;

  // One row of the directed table. Where typed is set, want replaces the
  // first token the row causes; all other tokens come from the predictor.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    token_t     want;
  } stim_row_t;

  localparam token_t NO_TOKEN = '0;

  localparam stim_row_t DIRECTED [25] = '{
    // end of text with nothing pending: a lone, balanced end token
    '{8'h00, 1'b1, 1'b1, '{KIND_END, 32'sd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    // one open paren, then end: counts differ
    '{CH_LPAREN, 1'b0, 1'b0, NO_TOKEN},
    '{8'h00, 1'b1, 1'b1, '{KIND_END, 32'sd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    // largest unsigned 32-bit value reads back as -1
    '{"4", 1'b0, 1'b0, NO_TOKEN},
    '{"2", 1'b0, 1'b0, NO_TOKEN},
    '{"9", 1'b0, 1'b0, NO_TOKEN},
    '{"4", 1'b0, 1'b0, NO_TOKEN},
    '{"9", 1'b0, 1'b0, NO_TOKEN},
    '{"6", 1'b0, 1'b0, NO_TOKEN},
    '{"7", 1'b0, 1'b0, NO_TOKEN},
    '{"2", 1'b0, 1'b0, NO_TOKEN},
    '{"9", 1'b0, 1'b0, NO_TOKEN},
    '{"5", 1'b0, 1'b0, NO_TOKEN},
    '{CH_MINUS, 1'b0, 1'b1, '{KIND_NUMBER, -32'sd1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
    // a digit inside a word: number 1 first, then the word "ab"
    '{"a", 1'b0, 1'b0, NO_TOKEN},
    '{"1", 1'b0, 1'b0, NO_TOKEN},
    '{"b", 1'b0, 1'b0, NO_TOKEN},
    '{CH_RPAREN, 1'b0, 1'b0, NO_TOKEN},
    // bare operators with nothing pending
    '{CH_MUL, 1'b0, 1'b0, NO_TOKEN},
    '{CH_DIV, 1'b0, 1'b0, NO_TOKEN},
    '{CH_POINT, 1'b0, 1'b0, NO_TOKEN},
    '{CH_PLUS, 1'b0, 1'b0, NO_TOKEN},
    // extreme bytes go into a word; end carries an operator that must be ignored
    '{8'hff, 1'b0, 1'b0, NO_TOKEN},
    '{8'h00, 1'b0, 1'b0, NO_TOKEN},
    '{CH_PLUS, 1'b1, 1'b0, NO_TOKEN}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ect_in_if  in_if ();
  ect_out_if out_if ();

  expression_char_tokenizer #(
    .WORD_CHARS(WORD_CHARS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: a private copy of what the tokenizer holds.
  logic                  num_pending;
  logic [31:0]           num_acc;
  logic                  word_pending;
  logic [7:0]            word_buf [WORD_CHARS];
  int unsigned           word_len;
  logic                  word_cut;
  logic [COUNT_BITS-1:0] opens;
  logic [COUNT_BITS-1:0] closes;

  token_t  item_tokens [$];   // tokens caused by the item just accepted
  token_t  tokens_due [$];    // tokens the block still owes, oldest first
  int      errors = 0;
  logic    idle_en;
  logic    hold_req;
  longint unsigned cycles = 0;

  function automatic token_t make_token(input token_kind_t kind, input logic [31:0] value,
                                        input logic [7:0] ch, input logic trunc,
                                        input logic mism, input logic done);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.ch    = ch;
    t.trunc = trunc;
    t.mism  = mism;
    t.done  = done;
    t.last  = 1'b0;
    return t;
  endfunction

  task automatic clear_state();
    num_pending  = 1'b0;
    num_acc      = '0;
    word_pending = 1'b0;
    word_len     = 0;
    word_cut     = 1'b0;
    opens        = '0;
    closes       = '0;
  endtask

  // Emit the pending number, then the pending word one character at a time.
  task automatic flush_pending();
    if (num_pending) begin
      item_tokens = {item_tokens,
                     make_token(KIND_NUMBER, num_acc, 8'h00, 1'b0, 1'b0, 1'b1)};
    end
    if (word_pending) begin
      for (int i = 0; i < word_len; i++) begin
        item_tokens = {item_tokens,
                       make_token(KIND_WORD, '0, word_buf[i], word_cut, 1'b0,
                                  (i + 1 == word_len))};
      end
    end
    num_pending  = 1'b0;
    num_acc      = '0;
    word_pending = 1'b0;
    word_len     = 0;
    word_cut     = 1'b0;
  endtask

  // Advance the predictor by one accepted item; fill item_tokens.
  task automatic tokenize_item(input logic [7:0] ch, input logic eot);
    token_kind_t kind;
    logic        is_op;
    token_t      t;
    item_tokens.delete();
    kind  = KIND_END;
    is_op = 1'b1;
    if (eot) begin
      flush_pending();
      t = make_token(KIND_END, '0, 8'h00, 1'b0, (opens != closes), 1'b1);
      t.last = 1'b1;
      item_tokens = {item_tokens, t};
      clear_state();
    end else begin
      case (ch)
        CH_PLUS:   kind = KIND_PLUS;
        CH_MINUS:  kind = KIND_MINUS;
        CH_MUL:    kind = KIND_MUL;
        CH_DIV:    kind = KIND_DIV;
        CH_POINT:  kind = KIND_POINT;
        CH_LPAREN: kind = KIND_LPAREN;
        CH_RPAREN: kind = KIND_RPAREN;
        default: begin
          is_op = 1'b0;
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            // decimal accumulate, wrapping at 32 bits
            num_pending = 1'b1;
            num_acc     = num_acc * DEC_BASE + 32'(ch - CH_ZERO);
          end else if (word_len < WORD_CHARS) begin
            word_pending       = 1'b1;
            word_buf[word_len] = ch;
            word_len++;
          end else begin
            // buffer full: drop the character, remember the cut
            word_pending = 1'b1;
            word_cut     = 1'b1;
          end
        end
      endcase
      if (is_op) begin
        flush_pending();
        t = make_token(kind, '0, 8'h00, 1'b0, 1'b0, 1'b1);
        t.last = 1'b1;
        item_tokens = {item_tokens, t};
        if (kind == KIND_LPAREN) begin
          opens = opens + COUNT_BITS'(1);
        end else if (kind == KIND_RPAREN) begin
          closes = closes + COUNT_BITS'(1);
        end
      end
    end
  endtask

  // Offer one item; return at the falling edge after it was accepted, with
  // valid still high so a following item can go out without a gap.
  task automatic send_item(input logic [7:0] ch, input logic eot, input logic typed,
                           input token_t want);
    while (idle_en && $urandom_range(99) < 36) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.text_char   <= ch;
    in_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    tokenize_item(ch, eot);
    if (typed) begin
      item_tokens[0] = want;
    end
    foreach (item_tokens[i]) begin
      tokens_due = {tokens_due, item_tokens[i]};
    end
    @(negedge clk_i);
  endtask

  // Drop valid and hold the sender until every owed token has arrived.
  task automatic wait_for_tokens();
    in_if.valid <= 1'b0;
    while (tokens_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_word_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POINT, CH_LPAREN, CH_RPAREN}
               || (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Output monitor: compare every accepted item against the oldest owed token.
  token_t owed;
  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d value %h char %h",
                 $time, out_if.token_kind, out_if.number_value, out_if.word_char);
        errors++;
      end else begin
        owed = tokens_due.pop_front();
        check_field("token_kind",     32'(owed.kind),  32'(out_if.token_kind));
        check_field("number_value",   owed.value,      out_if.number_value);
        check_field("word_char",      32'(owed.ch),    32'(out_if.word_char));
        check_field("word_truncated", 32'(owed.trunc), 32'(out_if.word_truncated));
        check_field("paren_mismatch", 32'(owed.mism),  32'(out_if.paren_mismatch));
        check_field("token_done",     32'(owed.done),  32'(out_if.token_done));
        check_field("last",           32'(owed.last),  32'(out_if.last));
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when asked for one.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          @(negedge clk_i);
        end
      end
      out_if.ready <= idle_en ? ($urandom_range(99) >= 36) : 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    in_if.valid       = 1'b0;
    in_if.text_char   = 8'h00;
    in_if.end_of_text = 1'b0;
    rst_ni            = 1'b0;
    idle_en           = 1'b1;
    hold_req          = 1'b0;
    clear_state();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].want);
    end
    wait_for_tokens();

    // Hold off the receiver while a long, truncated word, a number and a run
    // of operators queue up behind it; the input has to stall.
    hold_req = 1'b1;
    repeat (WORD_CHARS + 8) send_item(rand_word_char(), 1'b0, 1'b0, NO_TOKEN);
    repeat (6) send_item(8'(CH_ZERO + $urandom_range(9)), 1'b0, 1'b0, NO_TOKEN);
    foreach (OP_CHARS[i]) begin
      send_item(OP_CHARS[i], 1'b0, 1'b0, NO_TOKEN);
    end
    send_item(8'($urandom_range(255)), 1'b1, 1'b0, NO_TOKEN);
    wait_for_tokens();

    // Random expressions: numbers, words, operators, ends and raw noise bytes.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // mostly short numbers, now and then long enough to wrap
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        repeat (len) send_item(8'(CH_ZERO + $urandom_range(9)), 1'b0, 1'b0, NO_TOKEN);
      end else if (pick < 55) begin
        // mostly short words, now and then around the buffer size
        len = ($urandom_range(7) == 0) ? $urandom_range(WORD_CHARS - 1, WORD_CHARS + 8)
                                        : $urandom_range(1, 6);
        repeat (len) send_item(rand_word_char(), 1'b0, 1'b0, NO_TOKEN);
      end else if (pick < 85) begin
        len = 1;
        send_item(OP_CHARS[$urandom_range(6)], 1'b0, 1'b0, NO_TOKEN);
      end else if (pick < 91) begin
        len = 1;
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, NO_TOKEN);
      end else begin
        len = 1;
        send_item(8'($urandom_range(255)), 1'b0, 1'b0, NO_TOKEN);
      end
      sent += len;
    end
    send_item(8'($urandom_range(255)), 1'b1, 1'b0, NO_TOKEN);
    wait_for_tokens();

    // No idling on either side: a run of open parens back to back, then end
    // of text with the counts left unequal.
    idle_en = 1'b0;
    repeat (PAREN_RUN) send_item(CH_LPAREN, 1'b0, 1'b0, NO_TOKEN);
    send_item(8'h00, 1'b1, 1'b1, '{KIND_END, 32'sd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1});
    wait_for_tokens();

    // Let any stray output show up before deciding.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
